// File: rtl/ssr_pkg.sv
// Shared widths, codes and divider handshake types for the stepper speed ramp.
package ssr_pkg;

   localparam int unsigned DELAY_BITS = 16;
   localparam int unsigned COUNT_BITS = 24;
   localparam int unsigned REM_BITS   = 18;
   localparam int unsigned ACC_BITS   = COUNT_BITS + 1;

   // 2*delay + remainder, signed
   localparam int unsigned NUM_BITS =
      ((DELAY_BITS + 2 > REM_BITS) ? DELAY_BITS + 2 : REM_BITS) + 1;
   // 4*accel_count + 1, signed
   localparam int unsigned DEN_BITS = ACC_BITS + 2;
   // delay minus quotient, signed
   localparam int unsigned ND_BITS  = NUM_BITS + 2;

   localparam int unsigned CSR_DATA_BITS  = (COUNT_BITS > DELAY_BITS) ? COUNT_BITS : DELAY_BITS;
   localparam int unsigned CSR_INDEX_BITS = 3;

   localparam longint unsigned DELAY_MAX  = (64'd1 << DELAY_BITS) - 64'd1;
   localparam longint unsigned SINGLE_DLY = 64'd1000;
   localparam logic [DELAY_BITS-1:0] SINGLE_STEP_DELAY =
      (SINGLE_DLY < DELAY_MAX) ? DELAY_BITS'(SINGLE_DLY) : '1;
   localparam logic [DELAY_BITS-1:0] START_PERIOD = DELAY_BITS'(20);

   // configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MOVE_STEPS   = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIRST_DELAY  = CSR_INDEX_BITS'(1);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_DELAY    = CSR_INDEX_BITS'(2);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DECEL_LENGTH = CSR_INDEX_BITS'(3);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WATCH_SWITCH = CSR_INDEX_BITS'(4);

   // input action codes
   localparam logic ACTION_START = 1'b0;
   localparam logic ACTION_TICK  = 1'b1;

   typedef enum logic [3:0] {
      RUN_STOP  = 4'b0001,
      RUN_ACCEL = 4'b0010,
      RUN_RUN   = 4'b0100,
      RUN_DECEL = 4'b1000
   } run_state_type;

   typedef struct packed {
      logic                       start;
      logic signed [NUM_BITS-1:0] dividend;
      logic signed [DEN_BITS-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                     done;
      logic signed [NUM_BITS:0] quotient;
      logic signed [NUM_BITS:0] remainder;
   } div_rsp_type;

endpackage

// File: rtl/ssr_if.sv
// Request and response channel interfaces of the stepper speed ramp.
interface ssr_req_if;
   logic valid;
   logic ready;
   logic action;
   logic switch_open;

   modport source (output valid, output action, output switch_open, input ready);
   modport sink   (input valid, input action, input switch_open, output ready);
endinterface

interface ssr_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [ssr_pkg::DELAY_BITS-1:0]   period;
   logic [ssr_pkg::DELAY_BITS-2:0]   compare;
   logic                             pulse_enable;
   logic                             running;
   logic                             stopped_by_switch;
   logic                             timer_stop;

   modport source (output valid, output period, output compare, output pulse_enable,
                   output running, output stopped_by_switch, output timer_stop,
                   input ready);
   modport sink   (input valid, input period, input compare, input pulse_enable,
                   input running, input stopped_by_switch, input timer_stop,
                   output ready);
endinterface

// File: rtl/ssr_div.sv
// Radix-2 restoring signed divider, truncating quotient, remainder takes dividend sign.
module ssr_div (
   input  logic                 clock,
   input  logic                 reset,
   input  ssr_pkg::div_req_type div_req,
   output ssr_pkg::div_rsp_type div_rsp
);

   localparam int unsigned NB    = ssr_pkg::NUM_BITS;
   localparam int unsigned DB    = ssr_pkg::DEN_BITS;
   localparam int unsigned CNT_W = $clog2(NB);

   typedef enum logic [3:0] {
      DIV_IDLE = 4'b0001,
      DIV_PREP = 4'b0010,
      DIV_ITER = 4'b0100,
      DIV_FIX  = 4'b1000
   } div_state_type;

   div_state_type              state_ff, state_in;
   logic signed [NB-1:0]       num_raw_ff, num_raw_in;
   logic signed [DB-1:0]       den_raw_ff, den_raw_in;
   logic [NB-1:0]              quo_ff, quo_in;
   logic [DB-1:0]              rem_ff, rem_in;
   logic [DB-1:0]              dmag_ff, dmag_in;
   logic                       neg_q_ff, neg_q_in;
   logic                       neg_r_ff, neg_r_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   ssr_pkg::div_rsp_type       rsp_ff, rsp_in;

   logic [DB:0]                trial;
   logic [DB:0]                diff;
   logic                       fits;
   logic [NB:0]                qmag;
   logic [NB:0]                rmag;

   always_comb begin
      trial = {rem_ff, quo_ff[NB-1]};
      diff  = trial - {1'b0, dmag_ff};
      fits  = (trial >= {1'b0, dmag_ff});
      qmag  = {1'b0, quo_ff};
      rmag  = {1'b0, rem_ff[NB-1:0]};
   end

   always_comb begin
      state_in   = state_ff;
      num_raw_in = num_raw_ff;
      den_raw_in = den_raw_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      dmag_in    = dmag_ff;
      neg_q_in   = neg_q_ff;
      neg_r_in   = neg_r_ff;
      cnt_in     = cnt_ff;
      rsp_in     = rsp_ff;
      rsp_in.done = 1'b0;

      unique case (state_ff)
         DIV_IDLE: begin
            if (div_req.start) begin
               num_raw_in = div_req.dividend;
               den_raw_in = div_req.divisor;
               state_in   = DIV_PREP;
            end
         end
         DIV_PREP: begin
            quo_in   = num_raw_ff[NB-1] ? NB'(-num_raw_ff) : NB'(num_raw_ff);
            dmag_in  = den_raw_ff[DB-1] ? DB'(-den_raw_ff) : DB'(den_raw_ff);
            neg_q_in = num_raw_ff[NB-1] ^ den_raw_ff[DB-1];
            neg_r_in = num_raw_ff[NB-1];
            rem_in   = '0;
            cnt_in   = '0;
            state_in = DIV_ITER;
         end
         DIV_ITER: begin
            rem_in = fits ? diff[DB-1:0] : trial[DB-1:0];
            quo_in = {quo_ff[NB-2:0], fits};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NB - 1)) begin
               state_in = DIV_FIX;
            end
         end
         DIV_FIX: begin
            rsp_in.done      = 1'b1;
            rsp_in.quotient  = neg_q_ff ? -$signed(qmag) : $signed(qmag);
            rsp_in.remainder = neg_r_ff ? -$signed(rmag) : $signed(rmag);
            state_in         = DIV_IDLE;
         end
         default: state_in = DIV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= DIV_IDLE;
         rsp_ff.done <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rsp_ff.done <= rsp_in.done;
      end
      rsp_ff.quotient  <= rsp_in.quotient;
      rsp_ff.remainder <= rsp_in.remainder;
   end

   always_ff @(posedge clock) begin
      num_raw_ff       <= num_raw_in;
      den_raw_ff       <= den_raw_in;
      quo_ff           <= quo_in;
      rem_ff           <= rem_in;
      dmag_ff          <= dmag_in;
      neg_q_ff         <= neg_q_in;
      neg_r_ff         <= neg_r_in;
      cnt_ff           <= cnt_in;
   end

   assign div_rsp = rsp_ff;

endmodule

// File: rtl/stepper_speed_ramp.sv
// Top level: trapezoidal stepper step-timing generator with a shared serial divider.
//
//   channel  dir  handshake          payload
//   req_chan in   valid/ready        action, switch_open
//   rsp_chan out  valid/ready        period, compare, pulse_enable, running,
//                                    stopped_by_switch, timer_stop
//   csr_*    in   write enable only  csr_index, csr_write_data
//
// Start items and ticks in run or stop go from the idle step straight to the done step.
// Ticks in accel or decel also pass through the divide and post steps: the ramp division runs on one
// restoring divider, one quotient bit per cycle over NUM_BITS (19) bits.
// Ready is high only while the sequencer is idle; a finished result sits in the
// output register so the next item can be taken while rsp_chan is stalled.
// Synchronous active-high reset puts the ramp in stop with all counters cleared.
module stepper_speed_ramp (
   input  logic                                clock,
   input  logic                                reset,
   ssr_req_if.sink                             req_chan,
   ssr_rsp_if.source                           rsp_chan,
   input  logic                                csr_write_enable,
   input  logic [ssr_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [ssr_pkg::CSR_DATA_BITS-1:0]   csr_write_data
);

   localparam int unsigned DB  = ssr_pkg::DELAY_BITS;
   localparam int unsigned CB  = ssr_pkg::COUNT_BITS;
   localparam int unsigned RB  = ssr_pkg::REM_BITS;
   localparam int unsigned AB  = ssr_pkg::ACC_BITS;
   localparam int unsigned NB  = ssr_pkg::NUM_BITS;
   localparam int unsigned NDB = ssr_pkg::ND_BITS;

   // item sequencer
   typedef enum logic [3:0] {
      SEQ_IDLE = 4'b0001,
      SEQ_DIV  = 4'b0010,
      SEQ_POST = 4'b0100,
      SEQ_DONE = 4'b1000
   } seq_state_type;

   // configuration registers
   logic [CB-1:0] move_steps_ff, move_steps_in;
   logic [DB-1:0] first_delay_ff, first_delay_in;
   logic [DB-1:0] min_delay_ff, min_delay_in;
   logic [CB-1:0] decel_length_ff, decel_length_in;
   logic          watch_switch_ff, watch_switch_in;

   // ramp state
   ssr_pkg::run_state_type run_state_ff, run_state_in;
   logic [DB-1:0]          step_delay_ff, step_delay_in;
   logic signed [AB-1:0]   ramp_n_ff, ramp_n_in;
   logic [CB-1:0]          step_count_ff, step_count_in;
   logic signed [RB-1:0]   remainder_ff, remainder_in;
   logic [DB-1:0]          last_accel_delay_ff, last_accel_delay_in;
   logic [CB-1:0]          decel_start_ff, decel_start_in;
   logic                   output_enabled_ff, output_enabled_in;
   logic                   move_active_ff, move_active_in;

   // sequencer, pending result, output register
   seq_state_type          seq_ff, seq_in;
   logic [DB-1:0]          res_period_ff, res_period_in;
   logic                   res_pulse_ff, res_pulse_in;
   logic                   res_hit_ff, res_hit_in;
   logic                   res_tstop_ff, res_tstop_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DB-1:0]          rsp_period_ff, rsp_period_in;
   logic                   rsp_pulse_ff, rsp_pulse_in;
   logic                   rsp_running_ff, rsp_running_in;
   logic                   rsp_hit_ff, rsp_hit_in;
   logic                   rsp_tstop_ff, rsp_tstop_in;

   ssr_pkg::div_req_type   div_req_ff, div_req_in;
   ssr_pkg::div_rsp_type   div_rsp;

   // datapath helpers
   logic                   req_fire;
   logic                   out_free;
   logic [CB-1:0]          decel_len_eff;
   logic signed [AB-1:0]   decel_value;
   logic [CB-1:0]          step_count_inc;
   logic signed [AB-1:0]   ramp_n_inc;
   logic                   switch_hit;
   logic                   enabled_next;
   logic signed [NDB-1:0]  nd_wide;
   logic [DB-1:0]          nd_sat;
   logic signed [RB-1:0]   rem_sat;
   logic                   rem_ovf;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      decel_len_eff   = (decel_length_ff == '0) ? CB'(1) : decel_length_ff;
      decel_value     = -$signed({1'b0, decel_len_eff});
      step_count_inc  = (step_count_ff == '1) ? step_count_ff : step_count_ff + 1'b1;
      ramp_n_inc      = ramp_n_ff + AB'(1);
      switch_hit      = watch_switch_ff && req_chan.switch_open;
      enabled_next    = output_enabled_ff && !switch_hit;

      // next delay = d - q, held to the delay range
      nd_wide = NDB'($signed({1'b0, step_delay_ff})) - NDB'(div_rsp.quotient);
      if (nd_wide[NDB-1]) begin
         nd_sat = '0;
      end else if (|nd_wide[NDB-2:DB]) begin
         nd_sat = '1;
      end else begin
         nd_sat = nd_wide[DB-1:0];
      end

      // remainder held to the signed RB-bit range
      rem_ovf = (div_rsp.remainder[NB:RB-1] != '0) && (div_rsp.remainder[NB:RB-1] != '1);
      if (rem_ovf) begin
         rem_sat = div_rsp.remainder[NB] ? {1'b1, {(RB-1){1'b0}}} : {1'b0, {(RB-1){1'b1}}};
      end else begin
         rem_sat = div_rsp.remainder[RB-1:0];
      end
   end

   // configuration writes
   always_comb begin
      move_steps_in   = move_steps_ff;
      first_delay_in  = first_delay_ff;
      min_delay_in    = min_delay_ff;
      decel_length_in = decel_length_ff;
      watch_switch_in = watch_switch_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            ssr_pkg::CSR_MOVE_STEPS:   move_steps_in   = csr_write_data[CB-1:0];
            ssr_pkg::CSR_FIRST_DELAY:  first_delay_in  = csr_write_data[DB-1:0];
            ssr_pkg::CSR_MIN_DELAY:    min_delay_in    = csr_write_data[DB-1:0];
            ssr_pkg::CSR_DECEL_LENGTH: decel_length_in = csr_write_data[CB-1:0];
            ssr_pkg::CSR_WATCH_SWITCH: watch_switch_in = csr_write_data[0];
            default: ;
         endcase
      end
   end

   // sequencer and ramp update
   always_comb begin
      seq_in              = seq_ff;
      run_state_in        = run_state_ff;
      step_delay_in       = step_delay_ff;
      ramp_n_in           = ramp_n_ff;
      step_count_in       = step_count_ff;
      remainder_in        = remainder_ff;
      last_accel_delay_in = last_accel_delay_ff;
      decel_start_in      = decel_start_ff;
      output_enabled_in   = output_enabled_ff;
      move_active_in      = move_active_ff;
      res_period_in       = res_period_ff;
      res_pulse_in        = res_pulse_ff;
      res_hit_in          = res_hit_ff;
      res_tstop_in        = res_tstop_ff;
      div_req_in          = div_req_ff;
      div_req_in.start    = 1'b0;
      rsp_valid_in        = rsp_valid_ff && !rsp_chan.ready;
      rsp_period_in       = rsp_period_ff;
      rsp_pulse_in        = rsp_pulse_ff;
      rsp_running_in      = rsp_running_ff;
      rsp_hit_in          = rsp_hit_ff;
      rsp_tstop_in        = rsp_tstop_ff;

      unique case (seq_ff)
         SEQ_IDLE: begin
            if (req_fire) begin
               res_pulse_in = 1'b0;
               res_hit_in   = 1'b0;
               res_tstop_in = 1'b0;
               seq_in       = SEQ_DONE;
               if (req_chan.action == ssr_pkg::ACTION_START) begin
                  res_period_in = '0;
                  if (move_steps_ff != '0) begin
                     output_enabled_in = 1'b1;
                     move_active_in    = 1'b1;
                     step_count_in     = '0;
                     remainder_in      = '0;
                     ramp_n_in         = '0;
                     res_period_in     = ssr_pkg::START_PERIOD;
                     if (move_steps_ff == CB'(1)) begin
                        // single step: straight to decel, count at minus one
                        ramp_n_in     = '1;
                        run_state_in  = ssr_pkg::RUN_DECEL;
                        step_delay_in = ssr_pkg::SINGLE_STEP_DELAY;
                     end else begin
                        decel_start_in = (move_steps_ff > decel_len_eff) ?
                                         move_steps_ff - decel_len_eff : '0;
                        if (first_delay_ff <= min_delay_ff) begin
                           step_delay_in       = min_delay_ff;
                           last_accel_delay_in = min_delay_ff;
                           run_state_in        = ssr_pkg::RUN_RUN;
                        end else begin
                           step_delay_in = first_delay_ff;
                           run_state_in  = ssr_pkg::RUN_ACCEL;
                        end
                     end
                  end
               end else begin
                  res_period_in     = step_delay_ff;
                  res_hit_in        = switch_hit;
                  output_enabled_in = enabled_next;
                  if (!enabled_next) begin
                     // disabled output (or switch hit) always lands in stop
                     step_count_in  = '0;
                     remainder_in   = '0;
                     res_tstop_in   = 1'b1;
                     move_active_in = 1'b0;
                     run_state_in   = ssr_pkg::RUN_STOP;
                  end else begin
                     unique case (run_state_ff)
                        ssr_pkg::RUN_ACCEL, ssr_pkg::RUN_DECEL: begin
                           res_pulse_in        = 1'b1;
                           step_count_in       = step_count_inc;
                           ramp_n_in           = ramp_n_inc;
                           // num = 2d + rem, den = 4n + 1
                           div_req_in.start    = 1'b1;
                           div_req_in.dividend = NB'($signed({1'b0, step_delay_ff, 1'b0}))
                                                 + NB'(remainder_ff);
                           div_req_in.divisor  = {ramp_n_inc, 2'b01};
                           seq_in              = SEQ_DIV;
                        end
                        ssr_pkg::RUN_RUN: begin
                           res_pulse_in  = 1'b1;
                           step_count_in = step_count_inc;
                           step_delay_in = min_delay_ff;
                           if (step_count_inc >= decel_start_ff) begin
                              ramp_n_in     = decel_value;
                              step_delay_in = last_accel_delay_ff;
                              run_state_in  = ssr_pkg::RUN_DECEL;
                           end
                        end
                        default: begin
                           step_count_in  = '0;
                           remainder_in   = '0;
                           res_tstop_in   = 1'b1;
                           move_active_in = 1'b0;
                           run_state_in   = ssr_pkg::RUN_STOP;
                        end
                     endcase
                  end
               end
            end
         end
         SEQ_DIV: begin
            if (div_rsp.done) begin
               seq_in = SEQ_POST;
            end
         end
         SEQ_POST: begin
            // divider results are held in its output register
            step_delay_in = nd_sat;
            remainder_in  = rem_sat;
            if (run_state_ff == ssr_pkg::RUN_ACCEL) begin
               if (step_count_ff >= decel_start_ff) begin
                  ramp_n_in    = decel_value;
                  run_state_in = ssr_pkg::RUN_DECEL;
               end else if (nd_sat <= min_delay_ff) begin
                  last_accel_delay_in = nd_sat;
                  step_delay_in       = min_delay_ff;
                  remainder_in        = '0;
                  run_state_in        = ssr_pkg::RUN_RUN;
               end
            end else if (!ramp_n_ff[AB-1]) begin
               run_state_in = ssr_pkg::RUN_STOP;
            end
            seq_in = SEQ_DONE;
         end
         SEQ_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_period_in  = res_period_ff;
               rsp_pulse_in   = res_pulse_ff;
               rsp_running_in = move_active_ff;
               rsp_hit_in     = res_hit_ff;
               rsp_tstop_in   = res_tstop_ff;
               seq_in         = SEQ_IDLE;
            end
         end
         default: seq_in = SEQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         move_steps_ff       <= '0;
         first_delay_ff      <= '1;
         min_delay_ff        <= DB'(1);
         decel_length_ff     <= CB'(1);
         watch_switch_ff     <= 1'b0;
         run_state_ff        <= ssr_pkg::RUN_STOP;
         step_delay_ff       <= '0;
         ramp_n_ff           <= '0;
         step_count_ff       <= '0;
         remainder_ff        <= '0;
         last_accel_delay_ff <= '0;
         decel_start_ff      <= '0;
         output_enabled_ff   <= 1'b0;
         move_active_ff      <= 1'b0;
         seq_ff              <= SEQ_IDLE;
         div_req_ff          <= '0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         move_steps_ff       <= move_steps_in;
         first_delay_ff      <= first_delay_in;
         min_delay_ff        <= min_delay_in;
         decel_length_ff     <= decel_length_in;
         watch_switch_ff     <= watch_switch_in;
         run_state_ff        <= run_state_in;
         step_delay_ff       <= step_delay_in;
         ramp_n_ff           <= ramp_n_in;
         step_count_ff       <= step_count_in;
         remainder_ff        <= remainder_in;
         last_accel_delay_ff <= last_accel_delay_in;
         decel_start_ff      <= decel_start_in;
         output_enabled_ff   <= output_enabled_in;
         move_active_ff      <= move_active_in;
         seq_ff              <= seq_in;
         div_req_ff          <= div_req_in;
         rsp_valid_ff        <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_period_ff  <= res_period_in;
      res_pulse_ff   <= res_pulse_in;
      res_hit_ff     <= res_hit_in;
      res_tstop_ff   <= res_tstop_in;
      rsp_period_ff  <= rsp_period_in;
      rsp_pulse_ff   <= rsp_pulse_in;
      rsp_running_ff <= rsp_running_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_tstop_ff   <= rsp_tstop_in;
   end

   ssr_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req_ff),
      .div_rsp (div_rsp)
   );

   assign req_chan.ready             = (seq_ff == SEQ_IDLE);
   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.period            = rsp_period_ff;
   assign rsp_chan.compare           = rsp_period_ff[DB-1:1];
   assign rsp_chan.pulse_enable      = rsp_pulse_ff;
   assign rsp_chan.running           = rsp_running_ff;
   assign rsp_chan.stopped_by_switch = rsp_hit_ff;
   assign rsp_chan.timer_stop        = rsp_tstop_ff;

`ifndef SYNTHESIS
   // a stepping tick always belongs to an active move
   a_pulse_running: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_pulse_ff |-> rsp_running_ff)
      else $error("pulse enabled on an item with no active move");

   // a tick cannot both step and stop the timer
   a_pulse_tstop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_pulse_ff && rsp_tstop_ff))
      else $error("pulse enable and timer stop in the same item");

   // divider only answers while the sequencer waits on it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (seq_ff == SEQ_DIV))
      else $error("divider result outside the divide step");

   // a new output item is only loaded from the done step
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(seq_ff == SEQ_DONE))
      else $error("output item loaded outside the done step");
`endif

endmodule
